[rtl/marching_cubes_cell_triangulator_unit_defines.svh]
// Assertion macros for the marching cubes cell triangulator.
`ifndef MARCHING_CUBES_CELL_TRIANGULATOR_UNIT_DEFINES_SVH
`define MARCHING_CUBES_CELL_TRIANGULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define MCCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define MCCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mcct_pkg.sv]
// ----------------------------------------------------------------------------
// mcct_pkg
// Types, register indexes and constant tables of the cell triangulator.
// ----------------------------------------------------------------------------
`default_nettype none

package mcct_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COORD_BITS  = 12;
    localparam int DIM_BITS    = 11;
    localparam int FRAC_BITS   = 17;
    localparam int CFG_IDX_BITS = 8;

    localparam logic [DIM_BITS-1:0]  MAX_DIM  = 11'd1024;
    localparam logic [FRAC_BITS-1:0] FRAC_ONE  = 17'h10000;
    localparam logic [FRAC_BITS-1:0] FRAC_HALF = 17'h08000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ISO_LEVEL     = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VOLUME_WIDTH  = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VOLUME_HEIGHT = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VOLUME_DEPTH  = 8'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cube_x;
        logic signed [COORD_BITS-1:0] cube_y;
        logic signed [COORD_BITS-1:0] cube_z;
        logic [SAMPLE_BITS-1:0] corner_0;
        logic [SAMPLE_BITS-1:0] corner_1;
        logic [SAMPLE_BITS-1:0] corner_2;
        logic [SAMPLE_BITS-1:0] corner_3;
        logic [SAMPLE_BITS-1:0] corner_4;
        logic [SAMPLE_BITS-1:0] corner_5;
        logic [SAMPLE_BITS-1:0] corner_6;
        logic [SAMPLE_BITS-1:0] corner_7;
    } t_cube_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic [7:0]                   case_index;
        logic [3:0]                   edge_number;
        logic [FRAC_BITS-1:0]         fraction;
        logic                         on_border;
        logic                         last;
    } t_tri_out;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic load_case;
        logic prep;
        logic div_step;
        logic emit;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic trivial;
        logic direct;
        logic last_corner;
        logic out_free;
    } t_dp_status;

    // first and second corner of each cube edge
    function automatic logic [2:0] edge_first(input logic [3:0] e);
        logic [2:0] c;
        case (e)
            4'd0:    c = 3'd0;
            4'd1:    c = 3'd1;
            4'd2:    c = 3'd2;
            4'd3:    c = 3'd3;
            4'd4:    c = 3'd4;
            4'd5:    c = 3'd5;
            4'd6:    c = 3'd6;
            4'd7:    c = 3'd7;
            4'd8:    c = 3'd0;
            4'd9:    c = 3'd1;
            4'd10:   c = 3'd2;
            default: c = 3'd3;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] edge_second(input logic [3:0] e);
        logic [2:0] c;
        case (e)
            4'd0:    c = 3'd1;
            4'd1:    c = 3'd2;
            4'd2:    c = 3'd3;
            4'd3:    c = 3'd0;
            4'd4:    c = 3'd5;
            4'd5:    c = 3'd6;
            4'd6:    c = 3'd7;
            4'd7:    c = 3'd4;
            4'd8:    c = 3'd4;
            4'd9:    c = 3'd5;
            4'd10:   c = 3'd6;
            default: c = 3'd7;
        endcase
        return c;
    endfunction

    // Triangle table: top nibble is the corner count, then the edges in order.
    localparam logic [63:0] TRI_TABLE [256] = '{
        64'h0_000000000000000, 64'h3_083_000000000000, 64'h3_019_000000000000,
        64'h6_183981_000000000, 64'h3_12a_000000000000, 64'h6_08312a_000000000,
        64'h6_92a029_000000000, 64'h9_2832a8a98_000000,
        64'h3_3b2_000000000000, 64'h6_0b28b0_000000000, 64'h6_19023b_000000000,
        64'h9_1b219b98b_000000, 64'h6_3a1ba3_000000000, 64'h9_0a108a8ba_000000,
        64'h9_3903b9ba9_000000, 64'h6_98aa8b_000000000,
        64'h3_478_000000000000, 64'h6_430734_000000000, 64'h6_019847_000000000,
        64'h9_419471731_000000, 64'h6_12a847_000000000, 64'h9_34730412a_000000,
        64'h9_92a902847_000000, 64'hc_2a9297273794_000,
        64'h6_8473b2_000000000, 64'h9_b47b24204_000000, 64'h9_90184723b_000000,
        64'hc_47b94b9b2921_000, 64'h9_3a13ba784_000000, 64'hc_1ba14b1047b4_000,
        64'hc_47890b9bab03_000, 64'h9_47b4b99ba_000000,
        64'h3_954_000000000000, 64'h6_954083_000000000, 64'h6_054150_000000000,
        64'h9_854835315_000000, 64'h6_12a954_000000000, 64'h9_30812a495_000000,
        64'h9_52a542402_000000, 64'hc_2a5325354348_000,
        64'h6_95423b_000000000, 64'h9_0b208b495_000000, 64'h9_05401523b_000000,
        64'hc_21525828b485_000, 64'h9_a3ba13954_000000, 64'hc_4950818a18ba_000,
        64'hc_54050b5bab03_000, 64'h9_54858aa8b_000000,
        64'h6_978579_000000000, 64'h9_930953573_000000, 64'h9_078017157_000000,
        64'h6_153357_000000000, 64'h9_978957a12_000000, 64'hc_a12950530573_000,
        64'hc_802825857a52_000, 64'h9_2a5253357_000000,
        64'h9_7957893b2_000000, 64'hc_95797292027b_000, 64'hc_23b018178157_000,
        64'h9_b21b17715_000000, 64'hc_958857a13a3b_000, 64'hf_5705097b010aba0,
        64'hf_ba0b03a50807570, 64'h6_ba57b5_000000000,
        64'h3_a65_000000000000, 64'h6_0835a6_000000000, 64'h6_9015a6_000000000,
        64'h9_1831985a6_000000, 64'h6_165261_000000000, 64'h9_165126308_000000,
        64'h9_965906026_000000, 64'hc_598582526328_000,
        64'h6_23ba65_000000000, 64'h9_b08b20a65_000000, 64'h9_01923b5a6_000000,
        64'hc_5a61929b298b_000, 64'h9_63b653513_000000, 64'hc_08b0b50515b6_000,
        64'hc_3b6036065059_000, 64'h9_65969bb98_000000,
        64'h6_5a6478_000000000, 64'h9_43047365a_000000, 64'h9_1905a6847_000000,
        64'hc_a65197173794_000, 64'h9_612651478_000000, 64'hc_125526304347_000,
        64'hc_847905065026_000, 64'hf_739794329596269,
        64'h9_3b2784a65_000000, 64'hc_5a647242027b_000, 64'hc_01947823b5a6_000,
        64'hf_9219b294b7b45a6, 64'hc_8473b53515b6_000, 64'hf_51b5b610b7b404b,
        64'hf_059065036b63847, 64'hc_65969b4797b9_000,
        64'h6_a4964a_000000000, 64'h9_4a649a083_000000, 64'h9_a01a60640_000000,
        64'hc_83181686461a_000, 64'h9_149124264_000000, 64'hc_308129249264_000,
        64'h6_024426_000000000, 64'h9_832824426_000000,
        64'h9_a49a64b23_000000, 64'hc_08228b49a4a6_000, 64'hc_3b201606461a_000,
        64'hf_64161a48121b8b1, 64'hc_964936913b63_000, 64'hf_8b1810b61914641,
        64'h9_3b6360064_000000, 64'h6_648b68_000000000,
        64'h9_7a678a89a_000000, 64'hc_0730a709a67a_000, 64'hc_a671a7178180_000,
        64'h9_a67a71173_000000, 64'hc_126168189867_000, 64'hf_269291679093739,
        64'h9_780706602_000000, 64'h6_732672_000000000,
        64'hc_23ba68a89867_000, 64'hf_20727b09767a9a7, 64'hf_1801781a767a23b,
        64'hc_b21b17a61671_000, 64'hf_896867916b63136, 64'h6_091b67_000000000,
        64'hc_7807063b0b60_000, 64'h3_7b6_000000000000,
        64'h3_76b_000000000000, 64'h6_308b76_000000000, 64'h6_019b76_000000000,
        64'h9_819831b76_000000, 64'h6_a126b7_000000000, 64'h9_12a3086b7_000000,
        64'h9_2902a96b7_000000, 64'hc_6b72a3a83a98_000,
        64'h6_723627_000000000, 64'h9_708760620_000000, 64'h9_276237019_000000,
        64'hc_162186198876_000, 64'h9_a76a17137_000000, 64'hc_a7617a187108_000,
        64'hc_03707a0a96a7_000, 64'h9_76a7a88a9_000000,
        64'h6_684b86_000000000, 64'h9_36b306046_000000, 64'h9_86b846901_000000,
        64'hc_946963931b36_000, 64'h9_6846b82a1_000000, 64'hc_12a30b06b046_000,
        64'hc_4b846b0292a9_000, 64'hf_a93a32943b36463,
        64'h9_823842462_000000, 64'h6_042462_000000000, 64'hc_190234246438_000,
        64'h9_194142246_000000, 64'hc_8138618466a1_000, 64'h9_a10a06604_000000,
        64'hf_4634386a3039a93, 64'h6_a946a4_000000000,
        64'h6_49576b_000000000, 64'h9_083495b76_000000, 64'h9_50154076b_000000,
        64'hc_b76834354315_000, 64'h9_954a1276b_000000, 64'hc_6b712a083495_000,
        64'hc_76b54a42a402_000, 64'hf_348354325a52b76,
        64'h9_723762549_000000, 64'hc_954086062687_000, 64'hc_362376150540_000,
        64'hf_628687218485158, 64'hc_954a16176137_000, 64'hf_16a176107870954,
        64'hf_40a4a503a6a737a, 64'hc_76a7a854a48a_000,
        64'h9_6956b9b89_000000, 64'hc_36b063056095_000, 64'hc_0b805b01556b_000,
        64'h9_6b3635531_000000, 64'hc_12a95b9b8b56_000, 64'hf_0b306b09656912a,
        64'hf_b85b56805a52025, 64'hc_6b36352a3a53_000,
        64'hc_589528562382_000, 64'h9_956960062_000000, 64'hf_158180568382628,
        64'h6_156216_000000000, 64'hf_13616a386569896, 64'hc_a10a06950560_000,
        64'h6_03856a_000000000, 64'h3_a56_000000000000,
        64'h6_b5a75b_000000000, 64'h9_b5ab75830_000000, 64'h9_5b75ab190_000000,
        64'hc_a75ab7981831_000, 64'h9_b12b71751_000000, 64'hc_08312717572b_000,
        64'hc_9759279022b7_000, 64'hf_75272b592328982,
        64'h9_25a235375_000000, 64'hc_820852875a25_000, 64'hc_9015a35373a2_000,
        64'hf_982921872a25752, 64'h6_135375_000000000, 64'h9_087071175_000000,
        64'h9_903935537_000000, 64'h6_987597_000000000,
        64'h9_5845a8ab8_000000, 64'hc_5045b05abb30_000, 64'hc_01984a8aba45_000,
        64'hf_ab4a45b34941314, 64'hc_2512852b8458_000, 64'hf_04b0b345b2b151b,
        64'hf_0250592b5458b85, 64'h6_9452b3_000000000,
        64'hc_25a352345384_000, 64'h9_5a2524420_000000, 64'hf_3a235a385458019,
        64'hc_5a2524192942_000, 64'h9_845853351_000000, 64'h6_045105_000000000,
        64'hc_845853905035_000, 64'h3_945_000000000000,
        64'h9_4b749b9ab_000000, 64'hc_0834979b79ab_000, 64'hc_1ab1b414074b_000,
        64'hf_3143481a474bab4, 64'hc_4b79b492b912_000, 64'hf_9749b791b2b1083,
        64'h9_b74b42240_000000, 64'hc_b74b42834324_000,
        64'hc_29a279237749_000, 64'hf_9a7974a27870207, 64'hf_37a3a274a1a040a,
        64'h6_1a2874_000000000, 64'h9_491417713_000000, 64'hc_491417081871_000,
        64'h6_403743_000000000, 64'h3_487_000000000000,
        64'h6_9a8ab8_000000000, 64'h9_30939bb9a_000000, 64'h9_01a0a88ab_000000,
        64'h6_31ab3a_000000000, 64'h9_12b1b99b8_000000, 64'hc_30939b1292b9_000,
        64'h6_02b80b_000000000, 64'h3_32b_000000000000,
        64'h9_23828aa89_000000, 64'h6_9a2092_000000000, 64'hc_23828a0181a8_000,
        64'h3_1a2_000000000000, 64'h6_138918_000000000, 64'h3_091_000000000000,
        64'h3_038_000000000000, 64'h0_000000000000000
    };

endpackage

`default_nettype wire

[rtl/marching_cubes_cell_triangulator_unit.sv]
// Flow: an input beat goes through lookup, then per corner setup, divide
//   (skipped for direct fractions) and the output register.
// Accept: a new cube is taken only once the previous one is finished; the
//   radix-16 fraction divider sets the per-corner cost.
// Reset: synchronous, active low; config returns to iso 0 and sizes 1024.
// ----------------------------------------------------------------------------
// marching_cubes_cell_triangulator_unit
// One cube per input beat; one result beat per triangle corner of its case.
// ----------------------------------------------------------------------------
`default_nettype none

`include "marching_cubes_cell_triangulator_unit_defines.svh"

module marching_cubes_cell_triangulator_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // cube in
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  mcct_pkg::t_cube_in   i_in_data,
    // corner results out
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output mcct_pkg::t_tri_out   o_out_data,
    // register writes
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [7:0]            i_cfg_index,
    input  wire [15:0]           i_cfg_data
);
    import mcct_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // Register writes land directly in the config registers; always ready.
    assign o_cfg_ready = 1'b1;

    // Controller walks: idle -> lookup -> (setup -> divide -> emit) per
    // corner. The output register decouples the sink: a stalled result
    // only holds the emit step.
    mcct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // Datapath holds the cube, the table row being walked (shifted one
    // edge per emitted beat), the divider and the result register.
    mcct_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Empty and full cases never produce a beat.
    `MCCT_ASSERT_NOW(a_case_nontrivial, o_out_valid,
        (o_out_data.case_index != 8'h00) && (o_out_data.case_index != 8'hFF),
        "result beat for an empty or full cube")
    // Fraction stays within one in Q1.16.
    `MCCT_ASSERT_NOW(a_frac_range, o_out_valid,
        o_out_data.fraction <= 17'h10000, "fraction above one")
    // Edge codes come only from the twelve cube edges.
    `MCCT_ASSERT_NOW(a_edge_range, o_out_valid,
        o_out_data.edge_number <= 4'd11, "edge number out of range")
    // After taking a cube the block is not ready in the next cycle.
    `MCCT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready,
        !o_in_ready, "ready held after cube accepted")

endmodule

`default_nettype wire

[rtl/mcct_ctrl.sv]
// ----------------------------------------------------------------------------
// mcct_ctrl
// Sequencer: case lookup, per-corner fraction divide and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mcct_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output mcct_pkg::t_ctrl_cmd   o_cmd,
    input  mcct_pkg::t_dp_status  i_status
);
    import mcct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_div_cnt, n_div_cnt;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.load_case = 1'b1;
                n_state         = i_status.trivial ? S_IDLE : S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_div_cnt  = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (i_status.direct) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_div_cnt      = r_div_cnt + 2'd1;
                    if (r_div_cnt == 2'd3) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.last_corner ? S_IDLE : S_PREP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

endmodule

`default_nettype wire

[rtl/mcct_datapath.sv]
// ----------------------------------------------------------------------------
// mcct_datapath
// Config registers, cube latch, table walk, radix-16 fraction divider and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcct_datapath (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  mcct_pkg::t_ctrl_cmd   i_cmd,
    output mcct_pkg::t_dp_status  o_status,
    input  mcct_pkg::t_cube_in    i_in_data,
    input  wire                   i_cfg_valid,
    input  wire [7:0]             i_cfg_index,
    input  wire [15:0]            i_cfg_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output mcct_pkg::t_tri_out    o_out_data
);
    import mcct_pkg::*;

    // config
    logic [SAMPLE_BITS-1:0] r_iso;
    logic [DIM_BITS-1:0]    r_vol_w, r_vol_h, r_vol_d;
    logic [DIM_BITS-1:0]    cfg_dim;

    // cube
    logic signed [COORD_BITS-1:0] r_x, r_y, r_z;
    logic [SAMPLE_BITS-1:0]       r_smp [8];
    logic [7:0]                   r_ci;
    logic                         r_border;
    logic [59:0]                  r_tri;
    logic [3:0]                   r_len, r_idx;

    // fraction unit
    logic [3:0]             r_edge;
    logic                   r_direct;
    logic [FRAC_BITS-1:0]   r_dval;
    logic [SAMPLE_BITS-1:0] r_rem, r_den, r_quo;

    t_tri_out r_out;
    logic     r_out_valid;

    assign cfg_dim = (i_cfg_data[DIM_BITS-1:0] > MAX_DIM) ? MAX_DIM
                                                           : i_cfg_data[DIM_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso   <= '0;
            r_vol_w <= MAX_DIM;
            r_vol_h <= MAX_DIM;
            r_vol_d <= MAX_DIM;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ISO_LEVEL:     r_iso   <= i_cfg_data;
                CFG_VOLUME_WIDTH:  r_vol_w <= cfg_dim;
                CFG_VOLUME_HEIGHT: r_vol_h <= cfg_dim;
                CFG_VOLUME_DEPTH:  r_vol_d <= cfg_dim;
                default: ;
            endcase
        end
    end

    // case index and border test
    logic [7:0] ci;
    always_comb begin
        for (int n = 0; n < 8; n++) begin
            ci[n] = (r_smp[n] <= r_iso);
        end
    end

    function automatic logic axis_border(input logic signed [COORD_BITS-1:0] c,
                                         input logic [DIM_BITS-1:0] sz);
        logic signed [COORD_BITS:0] cw, lim;
        cw  = {c[COORD_BITS-1], c};
        lim = $signed({2'b00, sz}) - 13'sd1;
        return cw[COORD_BITS] | (cw >= lim);
    endfunction

    logic [63:0] tri_row;
    assign tri_row = TRI_TABLE[ci];

    // per-corner setup
    logic [3:0]             p_edge;
    logic [SAMPLE_BITS-1:0] p_fa, p_fb, p_num, p_den;
    logic                   p_direct;
    logic [FRAC_BITS-1:0]   p_dval;

    assign p_edge = r_tri[59:56];
    assign p_fa   = r_smp[edge_first(p_edge)];
    assign p_fb   = r_smp[edge_second(p_edge)];

    always_comb begin
        p_num    = '0;
        p_den    = '0;
        p_direct = 1'b1;
        p_dval   = '0;
        if (p_fa == p_fb) begin
            p_dval = FRAC_HALF;
        end else if (p_fb > p_fa) begin
            p_num = r_iso - p_fa;
            p_den = p_fb - p_fa;
            if (r_iso <= p_fa) begin
                p_dval = '0;
            end else if (p_num >= p_den) begin
                p_dval = FRAC_ONE;
            end else begin
                p_direct = 1'b0;
            end
        end else begin
            p_num = p_fa - r_iso;
            p_den = p_fa - p_fb;
            if (r_iso >= p_fa) begin
                p_dval = '0;
            end else if (p_num >= p_den) begin
                p_dval = FRAC_ONE;
            end else begin
                p_direct = 1'b0;
            end
        end
    end

    // four restoring steps per cycle
    logic [SAMPLE_BITS-1:0] d_rem, d_quo;
    logic [SAMPLE_BITS:0]   d_t;
    always_comb begin
        d_rem = r_rem;
        d_quo = r_quo;
        d_t   = '0;
        for (int k = 0; k < 4; k++) begin
            d_t = {d_rem, 1'b0};
            if (d_t >= {1'b0, r_den}) begin
                d_t   = d_t - {1'b0, r_den};
                d_quo = {d_quo[SAMPLE_BITS-2:0], 1'b1};
            end else begin
                d_quo = {d_quo[SAMPLE_BITS-2:0], 1'b0};
            end
            d_rem = d_t[SAMPLE_BITS-1:0];
        end
    end

    // round half up
    logic [FRAC_BITS-1:0] frac;
    logic                 rnd;
    assign rnd  = ({r_rem, 1'b0} >= {1'b0, r_den});
    assign frac = r_direct ? r_dval : ({1'b0, r_quo} + {{(FRAC_BITS-1){1'b0}}, rnd});

    logic last_corner;
    assign last_corner = (r_idx == (r_len - 4'd1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_x      <= i_in_data.cube_x;
            r_y      <= i_in_data.cube_y;
            r_z      <= i_in_data.cube_z;
            r_smp[0] <= i_in_data.corner_0;
            r_smp[1] <= i_in_data.corner_1;
            r_smp[2] <= i_in_data.corner_2;
            r_smp[3] <= i_in_data.corner_3;
            r_smp[4] <= i_in_data.corner_4;
            r_smp[5] <= i_in_data.corner_5;
            r_smp[6] <= i_in_data.corner_6;
            r_smp[7] <= i_in_data.corner_7;
        end
        if (i_cmd.load_case) begin
            r_ci     <= ci;
            r_len    <= tri_row[63:60];
            r_tri    <= tri_row[59:0];
            r_idx    <= '0;
            r_border <= axis_border(r_x, r_vol_w) | axis_border(r_y, r_vol_h)
                      | axis_border(r_z, r_vol_d);
        end
        if (i_cmd.prep) begin
            r_edge   <= p_edge;
            r_direct <= p_direct;
            r_dval   <= p_dval;
            r_rem    <= p_num;
            r_den    <= p_den;
            r_quo    <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= d_rem;
            r_quo <= d_quo;
        end
        if (i_cmd.emit) begin
            r_out.out_x       <= r_x;
            r_out.out_y       <= r_y;
            r_out.out_z       <= r_z;
            r_out.case_index  <= r_ci;
            r_out.edge_number <= r_edge;
            r_out.fraction    <= frac;
            r_out.on_border   <= r_border;
            r_out.last        <= last_corner;
            r_idx             <= r_idx + 4'd1;
            r_tri             <= {r_tri[55:0], 4'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.trivial     = (ci == 8'h00) || (ci == 8'hFF);
    assign o_status.direct      = r_direct;
    assign o_status.last_corner = last_corner;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
